@@ rtl/gha_pkg.sv @@
// shared types, request and status codes for the generational handle allocator
package gha_pkg;

	localparam int REQ_W = 3;
	localparam int ID_W = 10;
	localparam int VER_IN_W = 32;
	localparam int STATUS_W = 2;

	localparam int DEF_MAX_SLOTS = 1024;
	localparam int DEF_VERSION_BITS = 32;

	localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
	localparam logic [REQ_W-1:0] REQ_DESTROY = 3'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY = 3'd2;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic accept;
		logic pop_rd;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic pop_path;
	} sts_t;

endpackage

@@ rtl/generational_handle_allocator_core.sv @@
// top level of the generational handle allocator
// Hands out handles of slot id and version. An item is a request (create, destroy, query alive,
// lookup by id, clear all) and yields exactly one result item. An item is accepted in the idle
// state; for destroy, query, lookup, clear and a create that takes a fresh slot it then moves to
// the execute state, where the result register is loaded once the output register can take it.
// A create that reuses a freed slot passes through the pop state first, since the free stack
// read must finish before the slot table can be read at the popped id, and each table has one
// read port. The block takes the next item while a finished result still waits in the output
// register, and otherwise works on one item at a time. No clearing pass runs after reset: the
// high-water count marks which slot entries are valid.
module generational_handle_allocator_core #(
	parameter int MAX_SLOTS = gha_pkg::DEF_MAX_SLOTS,
	parameter int VERSION_BITS = gha_pkg::DEF_VERSION_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [gha_pkg::REQ_W-1:0]    req_type,
	input  logic [gha_pkg::ID_W-1:0]     entity_id,
	input  logic [gha_pkg::VER_IN_W-1:0] entity_version,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [gha_pkg::STATUS_W-1:0] status,
	output logic [gha_pkg::ID_W-1:0]     out_id,
	output logic [gha_pkg::VER_IN_W-1:0] out_version
);

	gha_pkg::cmd_t cmd;
	gha_pkg::sts_t sts;

	gha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	gha_datapath #(
		.MAX_SLOTS    (MAX_SLOTS),
		.VERSION_BITS (VERSION_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_type       (req_type),
		.entity_id      (entity_id),
		.entity_version (entity_version),
		.cmd            (cmd),
		.sts            (sts),
		.status         (status),
		.out_id         (out_id),
		.out_version    (out_version)
	);

	// a result is only loaded when the output register can take it
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || !out_stall))
		else $error("result loaded over a waiting result");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("result loaded but not presented");

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("item accepted while previous item still in work");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && (cmd.commit || cmd.pop_rd)))
		else $error("accept overlaps work on an earlier item");

endmodule

@@ rtl/gha_ctrl.sv @@
// controller state machine for the generational handle allocator
module gha_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  gha_pkg::sts_t sts,
	output gha_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_POP  = 3'b010,
		S_EXEC = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = sts.pop_path ? S_POP : S_EXEC;
				end
			end
			S_POP: begin
				cmd.pop_rd = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/gha_datapath.sv @@
// slot table, free stack, counters and result register
module gha_datapath #(
	parameter int MAX_SLOTS = gha_pkg::DEF_MAX_SLOTS,
	parameter int VERSION_BITS = gha_pkg::DEF_VERSION_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [gha_pkg::REQ_W-1:0]      req_type,
	input  logic [gha_pkg::ID_W-1:0]       entity_id,
	input  logic [gha_pkg::VER_IN_W-1:0]   entity_version,
	input  gha_pkg::cmd_t                  cmd,
	output gha_pkg::sts_t                  sts,
	output logic [gha_pkg::STATUS_W-1:0]   status,
	output logic [gha_pkg::ID_W-1:0]       out_id,
	output logic [gha_pkg::VER_IN_W-1:0]   out_version
);

	localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int VB = VERSION_BITS;
	localparam int CMP_W = (CW > gha_pkg::ID_W) ? CW : gha_pkg::ID_W;

	// slot word: alive flag above the version
	logic [VB:0] vmem [MAX_SLOTS];
	logic [IW-1:0] smem [MAX_SLOTS];

	logic [VB:0]   vrd_q;
	logic [IW-1:0] srd_q;
	logic [IW-1:0] vm_raddr;

	logic [gha_pkg::REQ_W-1:0]    req_q;
	logic [gha_pkg::ID_W-1:0]     id_q;
	logic [gha_pkg::VER_IN_W-1:0] ver_q;
	logic                         pop_q;

	logic [CW-1:0] used_q;
	logic [CW-1:0] free_q;
	logic [CW-1:0] used_d;
	logic [CW-1:0] free_d;

	logic [gha_pkg::STATUS_W-1:0] status_q;
	logic [gha_pkg::ID_W-1:0]     out_id_q;
	logic [gha_pkg::VER_IN_W-1:0] out_ver_q;

	logic [gha_pkg::STATUS_W-1:0] res_status;
	logic [gha_pkg::ID_W-1:0]     res_id;
	logic [gha_pkg::VER_IN_W-1:0] res_ver;

	logic          vm_we;
	logic [IW-1:0] vm_waddr;
	logic [VB:0]   vm_wdata;
	logic          sm_we;
	logic [IW-1:0] sm_waddr;
	logic [IW-1:0] sm_wdata;

	logic [VB-1:0] ver_inc;
	logic          in_range;
	logic          alive;
	logic          ver_match;
	logic          live;

	assign sts.pop_path = (req_type == gha_pkg::REQ_CREATE) && (free_q != '0);

	assign vm_raddr = cmd.pop_rd ? srd_q : IW'(entity_id);

	always_ff @(posedge clk) begin
		if (vm_we && cmd.commit) begin
			vmem[vm_waddr] <= vm_wdata;
		end
		if (cmd.accept || cmd.pop_rd) begin
			vrd_q <= vmem[vm_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (sm_we && cmd.commit) begin
			smem[sm_waddr] <= sm_wdata;
		end
		if (cmd.accept) begin
			smem_rd: srd_q <= smem[IW'(free_q - CW'(1))];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req_type;
			id_q <= entity_id;
			ver_q <= entity_version;
			pop_q <= sts.pop_path;
		end
		if (cmd.commit) begin
			status_q <= res_status;
			out_id_q <= res_id;
			out_ver_q <= res_ver;
		end
	end

	assign ver_inc = vrd_q[VB-1:0] + VB'(1);
	assign in_range = CMP_W'(id_q) < CMP_W'(used_q);
	assign alive = vrd_q[VB];
	assign ver_match = gha_pkg::VER_IN_W'(vrd_q[VB-1:0]) == ver_q;
	assign live = in_range && alive && ver_match;

	always_comb begin
		vm_we = 1'b0;
		vm_waddr = IW'(id_q);
		vm_wdata = {1'b0, vrd_q[VB-1:0]};
		sm_we = 1'b0;
		sm_waddr = free_q[IW-1:0];
		sm_wdata = IW'(id_q);
		used_d = used_q;
		free_d = free_q;
		res_status = gha_pkg::ST_BAD;
		res_id = '0;
		res_ver = '0;
		case (req_q)
			gha_pkg::REQ_CREATE: begin
				if (pop_q) begin
					vm_we = 1'b1;
					vm_waddr = srd_q;
					vm_wdata = {1'b1, ver_inc};
					free_d = free_q - CW'(1);
					res_status = gha_pkg::ST_OK;
					res_id = gha_pkg::ID_W'(srd_q);
					res_ver = gha_pkg::VER_IN_W'(ver_inc);
				end else if (used_q < CW'(MAX_SLOTS)) begin
					vm_we = 1'b1;
					vm_waddr = used_q[IW-1:0];
					vm_wdata = {1'b1, {VB{1'b0}}};
					used_d = used_q + CW'(1);
					res_status = gha_pkg::ST_OK;
					res_id = gha_pkg::ID_W'(used_q);
				end else begin
					res_status = gha_pkg::ST_FULL;
				end
			end
			gha_pkg::REQ_DESTROY: begin
				if (live && (free_q < CW'(MAX_SLOTS))) begin
					vm_we = 1'b1;
					sm_we = 1'b1;
					free_d = free_q + CW'(1);
					res_status = gha_pkg::ST_OK;
				end
			end
			gha_pkg::REQ_QUERY: begin
				if (live) begin
					res_status = gha_pkg::ST_OK;
				end
			end
			gha_pkg::REQ_LOOKUP: begin
				if (in_range && alive) begin
					res_status = gha_pkg::ST_OK;
					res_id = id_q;
					res_ver = gha_pkg::VER_IN_W'(vrd_q[VB-1:0]);
				end
			end
			gha_pkg::REQ_CLEAR: begin
				used_d = '0;
				free_d = '0;
				res_status = gha_pkg::ST_OK;
			end
			default: begin
				res_status = gha_pkg::ST_BAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			free_q <= '0;
		end else if (cmd.commit) begin
			used_q <= used_d;
			free_q <= free_d;
		end
	end

	assign status = status_q;
	assign out_id = out_id_q;
	assign out_version = out_ver_q;

endmodule

@@ test/generational_handle_allocator_core_test.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the generational handle allocator: random requests, shadow table
module generational_handle_allocator_core_test;

	typedef logic [gha_pkg::REQ_W-1:0] req_t;
	typedef logic [gha_pkg::ID_W-1:0] id_t;
	typedef logic [gha_pkg::VER_IN_W-1:0] ver_t;
	typedef logic [gha_pkg::STATUS_W-1:0] st_t;

	typedef struct packed {
		st_t status;
		id_t id;
		ver_t ver;
	} result_t;

	typedef struct packed {
		id_t id;
		ver_t ver;
	} handle_t;

	typedef struct packed {
		bit drain;
		req_t rq;
		id_t id;
		ver_t ver;
	} req_item_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t req_type = '0;
	id_t entity_id = '0;
	ver_t entity_version = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	st_t status;
	id_t out_id;
	ver_t out_version;

	// shadow tables: set 0 follows the generator, set 1 follows accepted items
	bit alive_tab [2][gha_pkg::DEF_MAX_SLOTS];
	ver_t ver_tab [2][gha_pkg::DEF_MAX_SLOTS];
	id_t free_tab [2][gha_pkg::DEF_MAX_SLOTS];
	int used_cnt [2];
	int free_cnt [2];

	req_item_t req_queue[$];
	result_t due_results[$];
	handle_t gen_live[$];
	handle_t gen_dead[$];

	int mismatches = 0;
	int results_seen = 0;
	int req_seen [8];
	int reused_cnt = 0;
	int full_cnt = 0;
	int tx_gap = 0;
	int rx_wait = 0;
	int tx_cyc = 0;
	int rx_cyc = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int idle_cycles = 0;
	req_item_t nxt;
	result_t exp_r;
	result_t rx_exp;

	generational_handle_allocator_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.entity_id(entity_id),
		.entity_version(entity_version),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.out_id(out_id),
		.out_version(out_version)
	);

	always #6 clk = ~clk;

	function automatic void handle_outcome(input int m, input req_t rq, input id_t id,
			input ver_t ver, output result_t r);
		bit live;
		id_t s;
		r = '{status: gha_pkg::ST_BAD, id: '0, ver: '0};
		live = int'(id) < used_cnt[m] && alive_tab[m][id] && ver_tab[m][id] == ver;
		case (rq)
			gha_pkg::REQ_CREATE: begin
				if (free_cnt[m] > 0) begin
					free_cnt[m]--;
					s = free_tab[m][free_cnt[m]];
					alive_tab[m][s] = 1'b1;
					ver_tab[m][s] = ver_tab[m][s] + 1'b1;
					r = '{status: gha_pkg::ST_OK, id: s, ver: ver_tab[m][s]};
				end else if (used_cnt[m] < gha_pkg::DEF_MAX_SLOTS) begin
					s = id_t'(used_cnt[m]);
					used_cnt[m]++;
					alive_tab[m][s] = 1'b1;
					ver_tab[m][s] = '0;
					r = '{status: gha_pkg::ST_OK, id: s, ver: '0};
				end else begin
					r.status = gha_pkg::ST_FULL;
				end
			end
			gha_pkg::REQ_DESTROY: begin
				if (live && free_cnt[m] < gha_pkg::DEF_MAX_SLOTS) begin
					alive_tab[m][id] = 1'b0;
					free_tab[m][free_cnt[m]] = id;
					free_cnt[m]++;
					r.status = gha_pkg::ST_OK;
				end
			end
			gha_pkg::REQ_QUERY: begin
				if (live)
					r.status = gha_pkg::ST_OK;
			end
			gha_pkg::REQ_LOOKUP: begin
				if (int'(id) < used_cnt[m] && alive_tab[m][id])
					r = '{status: gha_pkg::ST_OK, id: id, ver: ver_tab[m][id]};
			end
			gha_pkg::REQ_CLEAR: begin
				used_cnt[m] = 0;
				free_cnt[m] = 0;
				r.status = gha_pkg::ST_OK;
			end
			default: ;
		endcase
	endfunction

	task automatic push_req(input req_t rq, input id_t id, input ver_t ver);
		result_t r;
		req_item_t it;
		handle_t h;
		handle_outcome(0, rq, id, ver, r);
		if (r.status == gha_pkg::ST_OK) begin
			case (rq)
				gha_pkg::REQ_CREATE: begin
					h = '{id: r.id, ver: r.ver};
					gen_live.insert(gen_live.size(), h);
				end
				gha_pkg::REQ_DESTROY: begin
					for (int k = 0; k < gen_live.size(); k++) begin
						if (gen_live[k].id == id) begin
							gen_live.delete(k);
							break;
						end
					end
					h = '{id: id, ver: ver};
					gen_dead.insert(gen_dead.size(), h);
					if (gen_dead.size() > 32)
						void'(gen_dead.pop_front());
				end
				gha_pkg::REQ_CLEAR: gen_live.delete();
				default: ;
			endcase
		end
		it = '{drain: 1'b0, rq: rq, id: id, ver: ver};
		req_queue.insert(req_queue.size(), it);
	endtask

	task automatic push_drain();
		req_item_t it;
		it = '{drain: 1'b1, rq: '0, id: '0, ver: '0};
		req_queue.insert(req_queue.size(), it);
	endtask

	task automatic rand_req(input int w_create, input int w_clear);
		int pick;
		int k;
		handle_t h;
		req_t rq;
		id_t id;
		ver_t ver;
		pick = int'($urandom_range(0, 99));
		if (pick < w_clear) begin
			push_req(gha_pkg::REQ_CLEAR, id_t'($urandom), ver_t'($urandom));
		end else if (pick < w_clear + 3) begin
			push_req(req_t'($urandom_range(5, 7)), id_t'($urandom), ver_t'($urandom));
		end else if (pick < w_clear + 3 + w_create) begin
			push_req(gha_pkg::REQ_CREATE, id_t'($urandom), ver_t'($urandom));
		end else begin
			k = int'($urandom_range(0, 2));
			rq = (k == 0) ? gha_pkg::REQ_DESTROY :
				(k == 1) ? gha_pkg::REQ_QUERY : gha_pkg::REQ_LOOKUP;
			k = int'($urandom_range(0, 19));
			if (gen_live.size() > 0 && k < 13) begin
				h = gen_live[$urandom_range(0, gen_live.size() - 1)];
				id = h.id;
				ver = h.ver;
			end else if (gen_live.size() > 0 && k < 15) begin
				h = gen_live[$urandom_range(0, gen_live.size() - 1)];
				id = h.id;
				ver = h.ver ^ (ver_t'(1) << $urandom_range(0, gha_pkg::VER_IN_W - 1));
			end else if (gen_dead.size() > 0 && k < 17) begin
				h = gen_dead[$urandom_range(0, gen_dead.size() - 1)];
				id = h.id;
				ver = h.ver;
			end else begin
				id = id_t'($urandom);
				ver = $urandom_range(0, 1) ? ver_t'($urandom) : ver_t'($urandom_range(0, 3));
			end
			push_req(rq, id, ver);
		end
	endtask

	function automatic int idle_len(input bit calm);
		int r;
		r = int'($urandom_range(0, 99));
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(8, 40));
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				if (req_type == gha_pkg::REQ_CREATE && free_cnt[1] > 0)
					reused_cnt++;
				handle_outcome(1, req_type, entity_id, entity_version, exp_r);
				if (req_type == gha_pkg::REQ_CREATE && exp_r.status == gha_pkg::ST_FULL)
					full_cnt++;
				due_results.insert(due_results.size(), exp_r);
				req_seen[req_type]++;
			end
			tx_cyc++;
			if (tx_cyc % 128 == 0)
				tx_calm = ($urandom_range(0, 3) == 0);
			if (!in_valid || !in_stall) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else begin
					if (req_queue.size() > 0 && req_queue[0].drain && due_results.size() == 0)
						void'(req_queue.pop_front());
					if (req_queue.size() > 0 && !req_queue[0].drain) begin
						nxt = req_queue.pop_front();
						in_valid <= 1'b1;
						req_type <= nxt.rq;
						entity_id <= nxt.id;
						entity_version <= nxt.ver;
						tx_gap = idle_len(tx_calm);
					end else begin
						in_valid <= 1'b0;
					end
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: status %0d id %0d version %0h",
							status, out_id, out_version);
				end else begin
					rx_exp = due_results.pop_front();
					if (status !== rx_exp.status || out_id !== rx_exp.id ||
							out_version !== rx_exp.ver) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: expected status %0d id %0d version %0h,",
								results_seen, rx_exp.status, rx_exp.id, rx_exp.ver,
								" got status %0d id %0d version %0h",
								status, out_id, out_version);
					end
				end
				if (results_seen == 250 || results_seen == 1100)
					rx_wait = LONG_HOLD;
			end
			rx_cyc++;
			if (rx_cyc % 128 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			if (rx_wait > 0) begin
				out_stall <= 1'b1;
				rx_wait--;
			end else begin
				rx_wait = idle_len(rx_calm);
				out_stall <= (rx_wait > 0);
				if (rx_wait > 0)
					rx_wait--;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d cycles with no item moving", idle_cycles);
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		used_cnt[0] = 0;
		used_cnt[1] = 0;
		free_cnt[0] = 0;
		free_cnt[1] = 0;
		for (int k = 0; k < 8; k++)
			req_seen[k] = 0;

		// directed: empty table, fresh slots, mismatches, dead slots, reuse, unknown codes, clear
		push_req(gha_pkg::REQ_LOOKUP, id_t'(0), ver_t'(0));
		push_req(gha_pkg::REQ_DESTROY, '1, '1);
		push_req(gha_pkg::REQ_QUERY, id_t'(0), ver_t'(0));
		push_req(gha_pkg::REQ_CREATE, '0, '0);
		push_req(gha_pkg::REQ_CREATE, '1, '1);
		push_req(gha_pkg::REQ_QUERY, id_t'(0), ver_t'(0));
		push_req(gha_pkg::REQ_QUERY, id_t'(0), '1);
		push_req(gha_pkg::REQ_QUERY, id_t'(1), ver_t'(32'h8000_0000));
		push_req(gha_pkg::REQ_LOOKUP, id_t'(1), '1);
		push_req(gha_pkg::REQ_LOOKUP, id_t'(2), ver_t'(0));
		push_req(gha_pkg::REQ_DESTROY, id_t'(0), ver_t'(1));
		push_req(gha_pkg::REQ_DESTROY, id_t'(0), ver_t'(0));
		push_req(gha_pkg::REQ_DESTROY, id_t'(0), ver_t'(0));
		push_req(gha_pkg::REQ_QUERY, id_t'(0), ver_t'(0));
		push_req(gha_pkg::REQ_LOOKUP, id_t'(0), ver_t'(0));
		push_req(gha_pkg::REQ_CREATE, '0, '0);
		push_req(gha_pkg::REQ_DESTROY, id_t'(1), ver_t'(0));
		push_req(gha_pkg::REQ_DESTROY, id_t'(0), ver_t'(1));
		push_req(gha_pkg::REQ_CREATE, '0, '0);
		push_req(gha_pkg::REQ_CREATE, '0, '0);
		for (int k = 5; k < 8; k++)
			push_req(req_t'(k), id_t'($urandom), ver_t'($urandom));
		push_req(gha_pkg::REQ_CLEAR, '1, '1);
		push_req(gha_pkg::REQ_LOOKUP, id_t'(0), ver_t'(0));
		push_req(gha_pkg::REQ_CREATE, '0, '0);
		push_req(gha_pkg::REQ_QUERY, id_t'(0), ver_t'(0));
		push_drain();

		// small live population, lots of slot reuse
		repeat (220)
			rand_req(25, 2);
		push_drain();

		// fill the table to the top
		push_req(gha_pkg::REQ_CLEAR, '0, '0);
		while (used_cnt[0] < gha_pkg::DEF_MAX_SLOTS) begin
			if ($urandom_range(0, 9) < 8)
				push_req(gha_pkg::REQ_CREATE, id_t'($urandom), ver_t'($urandom));
			else
				rand_req(0, 0);
		end
		while (free_cnt[0] > 0)
			push_req(gha_pkg::REQ_CREATE, id_t'($urandom), ver_t'($urandom));
		repeat (3)
			push_req(gha_pkg::REQ_CREATE, id_t'($urandom), ver_t'($urandom));
		push_req(gha_pkg::REQ_LOOKUP, '1, '0);
		push_req(gha_pkg::REQ_QUERY, '1, ver_tab[0][gha_pkg::DEF_MAX_SLOTS-1]);
		push_req(gha_pkg::REQ_DESTROY, '1, ~ver_tab[0][gha_pkg::DEF_MAX_SLOTS-1]);
		push_req(gha_pkg::REQ_DESTROY, '1, ver_tab[0][gha_pkg::DEF_MAX_SLOTS-1]);
		push_req(gha_pkg::REQ_QUERY, '1, ver_tab[0][gha_pkg::DEF_MAX_SLOTS-1]);
		push_req(gha_pkg::REQ_CREATE, '0, '0);
		push_req(gha_pkg::REQ_CREATE, '0, '0);
		push_req(gha_pkg::REQ_LOOKUP, '1, '1);
		push_drain();

		// mixed traffic with occasional clears
		repeat (150)
			rand_req(25, 2);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (req_queue.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("run covered %0d creates (%0d reused a freed slot, %0d hit a full table),",
			req_seen[gha_pkg::REQ_CREATE], reused_cnt, full_cnt,
			" %0d destroys, %0d queries, %0d lookups",
			req_seen[gha_pkg::REQ_DESTROY], req_seen[gha_pkg::REQ_QUERY],
			req_seen[gha_pkg::REQ_LOOKUP]);
		$display("plus %0d clears and %0d unknown codes; %0d results checked, %0d mismatches",
			req_seen[gha_pkg::REQ_CLEAR], req_seen[5] + req_seen[6] + req_seen[7],
			results_seen, mismatches);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
